// ----- design/csb_pkg.sv -----
// Shared types and constants for the cross stencil blur unit.
// Used by the lanes, the merge stage, the top level and the checker.
`default_nettype none

package csb_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned PIX_BITS      = 8;
  localparam int unsigned RGB_BITS      = 24;
  localparam int unsigned IMG_W_BITS    = 11;
  localparam int unsigned IMG_H_BITS    = 16;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // Register reset values.
  localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

  // The weighted sum of five taps (centre counted twice) is at most 6*255.
  localparam int unsigned SUM_BITS = 11;

  // Division by six as a multiply by ceil(2^13/6) and a shift; exact for sums up to 1530.
  localparam logic [SUM_BITS-1:0] DIV6_RECIP = 11'd1366;
  localparam int unsigned         DIV6_SHIFT = 13;

  // Result queue of the merge stage.
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_BITS = 2;
  localparam int unsigned FIFO_CNT_BITS = 3;

  // Register index, taken from address bit 2.
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } csb_reg_e;

  // What one input word releases.
  typedef struct packed {
    logic has_filt;  // filtered pixel of the previous row
    logic has_pass;  // the current pixel itself, on the last row
    logic eof;       // final pixel of the frame
  } csb_flags_t;

  // One queued result word.
  typedef struct packed {
    logic                eof;
    logic                last;
    logic [RGB_BITS-1:0] rgb;
  } csb_result_t;

endpackage

`default_nettype wire

// ----- design/csb_line_store.sv -----
// Two-row line store: each entry holds {older row, newer row} of one column.
// One write port, two registered read ports; depends on nothing else.
`default_nettype none

module csb_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [2*DW-1:0]          wdata_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [2*DW-1:0]          rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [DW-1:0]            rdata_b_o
);

  logic [2*DW-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports return the contents from before a write at the same edge.
  // Port B sees only the newer row.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i][DW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/csb_lane.sv -----
// One colour channel of the cross stencil: weighted sum, then division by six.
// Two register stages; uses constants from csb_pkg.
`default_nettype none

module csb_lane
  import csb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic                border_i,
  input  wire logic [PIX_BITS-1:0] up_i,
  input  wire logic [PIX_BITS-1:0] left_i,
  input  wire logic [PIX_BITS-1:0] centre_i,
  input  wire logic [PIX_BITS-1:0] right_i,
  input  wire logic [PIX_BITS-1:0] down_i,
  output logic      [PIX_BITS-1:0] pix_o
);

  localparam int unsigned PROD_BITS = 2 * SUM_BITS;

  logic [SUM_BITS-1:0]  sum_d, sum_q;
  logic [PIX_BITS-1:0]  centre_q;
  logic                 border_q;
  logic [PROD_BITS-1:0] prod;
  logic [PIX_BITS-1:0]  quo;
  logic [PIX_BITS-1:0]  pix_d, pix_q;

  // First stage: the five-point sum with the centre weighted twice.
  assign sum_d = SUM_BITS'(up_i) + SUM_BITS'(left_i) + SUM_BITS'({centre_i, 1'b0})
               + SUM_BITS'(right_i) + SUM_BITS'(down_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q    <= sum_d;
      centre_q <= centre_i;
      border_q <= border_i;
    end
  end

  // Second stage: divide by six through the reciprocal; border pixels keep the centre.
  assign prod  = PROD_BITS'(sum_q) * PROD_BITS'(DIV6_RECIP);
  assign quo   = prod[DIV6_SHIFT +: PIX_BITS];
  assign pix_d = border_q ? centre_q : quo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

// ----- design/csb_merge.sv -----
// Merge stage: packs the lane results and the pass-through pixel into result words
// and queues them for the output channel. Uses types from csb_pkg.
`default_nettype none

module csb_merge
  import csb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire csb_flags_t          flags_i,
  input  wire logic [RGB_BITS-1:0] filt_rgb_i,
  input  wire logic [RGB_BITS-1:0] pass_rgb_i,
  output logic                     ready_o,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output logic      [RGB_BITS-1:0] res_rgb_o,
  output logic                     res_last_o,
  output logic                     res_eof_o
);

  csb_result_t             fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] count_d, count_q, n_push;
  csb_result_t             res_filt, res_pass;
  logic                    pop;

  // The filtered word closes the run unless the current pixel follows it.
  always_comb begin
    res_filt.eof  = flags_i.eof & ~flags_i.has_pass;
    res_filt.last = ~flags_i.has_pass;
    res_filt.rgb  = filt_rgb_i;
    res_pass.eof  = flags_i.eof;
    res_pass.last = 1'b1;
    res_pass.rgb  = pass_rgb_i;
  end

  // Up to two words enter per cycle; the filtered one goes first.
  always_ff @(posedge clk_i) begin
    if (push_i && flags_i.has_filt) begin
      fifo_q[wr_ptr_q] <= res_filt;
    end
    if (push_i && flags_i.has_pass) begin
      fifo_q[wr_ptr_q + FIFO_PTR_BITS'(flags_i.has_filt)] <= res_pass;
    end
  end

  // Pointer and fill bookkeeping.
  always_comb begin
    n_push   = push_i ? (FIFO_CNT_BITS'(flags_i.has_filt) + FIFO_CNT_BITS'(flags_i.has_pass))
                      : '0;
    pop      = (count_q != '0) && res_ready_i;
    wr_ptr_d = wr_ptr_q + FIFO_PTR_BITS'(n_push);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_BITS'(pop);
    count_d  = count_q + n_push - FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Room for two more words keeps the pipeline moving.
  assign ready_o     = count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
  assign res_valid_o = count_q != '0;
  assign res_rgb_o   = fifo_q[rd_ptr_q].rgb;
  assign res_last_o  = fifo_q[rd_ptr_q].last;
  assign res_eof_o   = fifo_q[rd_ptr_q].eof;

endmodule

`default_nettype wire

// ----- design/cross_stencil_blur_rgb_unit.sv -----
// Cross stencil blur over an RGB raster stream: top level.
// Depends on csb_pkg, csb_line_store, csb_lane and csb_merge.
//
// Usage: pixels enter in raster order on the s_axis channel, one word per pixel.
// Each pixel of row y >= 1 releases the pixel of row y-1 at the same column,
// blurred as (up + left + 2*centre + right + down) / 6 per channel, or unchanged
// on the frame border. Pixels of the last row also release themselves as a second
// word. m_axis_tlast marks the last word released by one input pixel, and
// m_axis_tuser marks the word that carries the final pixel of the frame.
// Frame size is set through the APB registers; a write restarts the frame.
// A result passes stage 1, the two lane stages and the result queue before it can be taken.
// Throughput: one pixel per cycle while the result queue has room, set by the one
// read and one write per cycle of the line store; on the last row two result words
// per pixel leave through the single output channel, so that row runs at half that rate.
// Reset clears the counters, the pipeline and the result queue; the line store is
// not cleared; stale entries reach only discarded results and border pixels.
// When the receiver stalls, the result queue fills and s_axis_tready drops once
// fewer than two free places remain; no word is lost.
`default_nettype none

module cross_stencil_blur_rgb_unit
  import csb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned CHANNELS  = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  // Pixel input
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [RGB_BITS-1:0]      s_axis_tdata,   // red_in, green_in, blue_in
  // Result output
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic      [RGB_BITS-1:0]      m_axis_tdata,   // red_out, green_out, blue_out
  output logic                          m_axis_tlast,
  output logic      [0:0]               m_axis_tuser    // end_of_frame
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = CHANNELS * PIX_BITS;

  // Configuration registers and counters
  logic [IMG_W_BITS-1:0] width_q;
  logic [IMG_H_BITS-1:0] height_q;
  logic                  cfg_wr;
  logic [31:0]           width_ext, wlast_ext;
  logic [XW-1:0]         wlast;
  logic [IMG_H_BITS-1:0] hlast;
  logic [XW-1:0]         col_d, col_q;
  logic [IMG_H_BITS-1:0] row_d, row_q;

  // Pipeline
  logic                  en, in_fire;
  logic [CHANNELS-1:0][PIX_BITS-1:0] cur_in;
  csb_flags_t            flags_in;
  logic                  border_in;
  logic                  s1_valid_q, s2_valid_q, s3_valid_q;
  csb_flags_t            s1_flags_q, s2_flags_q, s3_flags_q;
  logic                  s1_border_q;
  logic [XW-1:0]         s1_x_q;
  logic [PW-1:0]         s1_cur_q, s2_cur_q, s3_cur_q;
  logic                  s1_fwd_q;
  logic [2*PW-1:0]       fwd_entry_q;
  logic [2*PW-1:0]       rd_a, entry, wdata;
  logic [PW-1:0]         rd_b;
  logic [PW-1:0]         left_q;
  logic [CHANNELS-1:0][PIX_BITS-1:0] up_px, left_px, centre_px, right_px, down_px, lane_pix;
  logic [RGB_BITS-1:0]   filt_rgb, pass_rgb;
  logic                  merge_ready;
  logic                  res_eof;

  // Register writes restart the frame.
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (csb_reg_e'(paddr[2])
      )
        REG_IMAGE_WIDTH:  width_q  <= pwdata[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (csb_reg_e'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_q);
      default:          prdata = '0;
    endcase
  end

  // Last column and last row; a zero size acts as one, a wide frame is capped.
  always_comb begin
    width_ext = 32'(width_q);
    if (width_q == '0) begin
      wlast_ext = '0;
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      wlast_ext = 32'(MAX_WIDTH) - 32'd1;
    end else begin
      wlast_ext = width_ext - 32'd1;
    end
    wlast = wlast_ext[XW-1:0];
    hlast = (height_q == '0) ? '0 : height_q - 16'd1;
  end

  // Input handshake: the whole pipeline advances while the queue has room.
  assign en            = merge_ready;
  assign s_axis_tready = en;
  assign in_fire       = s_axis_tvalid & en;

  // Raster position.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_q == wlast) begin
        col_d = '0;
        row_d = (row_q == hlast) ? '0 : row_q + 16'd1;
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Channels beyond the three input fields take zero.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_cur
    if (c < 3) begin : g_field
      assign cur_in[c] = s_axis_tdata[c*PIX_BITS +: PIX_BITS];
    end else begin : g_zero
      assign cur_in[c] = '0;
    end
  end

  // What this pixel releases, decided from its position.
  always_comb begin
    flags_in.has_filt = row_q != '0;
    flags_in.has_pass = row_q == hlast;
    flags_in.eof      = (col_q == wlast) && (row_q == hlast);
    border_in         = (row_q == 16'd1) || (col_q == '0) || (col_q == wlast);
  end

  // Line store: entry at x for up and centre, newer row at x+1 for right.
  csb_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (PW)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (s1_valid_q & en),
    .waddr_i   (s1_x_q),
    .wdata_i   (wdata),
    .rd_en_i   (in_fire),
    .raddr_a_i (col_q),
    .rdata_a_o (rd_a),
    .raddr_b_i (col_q + XW'(1)),
    .rdata_b_o (rd_b)
  );

  // Stage 1: line store data returns. With a one-pixel row, the entry written at
  // the same edge as the read is forwarded.
  assign entry = s1_fwd_q ? fwd_entry_q : rd_a;
  assign wdata = {entry[PW-1:0], s1_cur_q};

  always_comb begin
    up_px     = entry[2*PW-1:PW];
    centre_px = entry[PW-1:0];
    right_px  = rd_b;
    left_px   = left_q;
    down_px   = s1_cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q      <= col_q;
      s1_cur_q    <= cur_in;
      s1_flags_q  <= flags_in;
      s1_border_q <= border_in;
      fwd_entry_q <= wdata;
    end
    if (s1_valid_q && en) begin
      left_q <= entry[PW-1:0];
    end
    if (en) begin
      s2_flags_q <= s1_flags_q;
      s2_cur_q   <= s1_cur_q;
      s3_flags_q <= s2_flags_q;
      s3_cur_q   <= s2_cur_q;
    end
  end

  // Stage valid bits and the forwarding mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_fire;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s1_fwd_q   <= in_fire & s1_valid_q & (s1_x_q == col_q);
    end
  end

  // One lane per channel; stages 2 and 3 live inside the lanes.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    csb_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .border_i (s1_border_q),
      .up_i     (up_px[c]),
      .left_i   (left_px[c]),
      .centre_i (centre_px[c]),
      .right_i  (right_px[c]),
      .down_i   (down_px[c]),
      .pix_o    (lane_pix[c])
    );
  end

  // Map the lanes onto the three colour fields; missing channels read zero.
  for (genvar c = 0; c < 3; c++) begin : g_rgb
    if (c < CHANNELS) begin : g_used
      assign filt_rgb[c*PIX_BITS +: PIX_BITS] = lane_pix[c];
      assign pass_rgb[c*PIX_BITS +: PIX_BITS] = s3_cur_q[c*PIX_BITS +: PIX_BITS];
    end else begin : g_unused
      assign filt_rgb[c*PIX_BITS +: PIX_BITS] = '0;
      assign pass_rgb[c*PIX_BITS +: PIX_BITS] = '0;
    end
  end

  // Merge stage and result queue.
  csb_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q & en),
    .flags_i     (s3_flags_q),
    .filt_rgb_i  (filt_rgb),
    .pass_rgb_i  (pass_rgb),
    .ready_o     (merge_ready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_rgb_o   (m_axis_tdata),
    .res_last_o  (m_axis_tlast),
    .res_eof_o   (res_eof)
  );

  assign m_axis_tuser = res_eof;

endmodule

`default_nettype wire

// ----- design/csb_checker.sv -----
// Port-level checks for the cross stencil blur unit, bound to the top level.
// Depends on csb_pkg and cross_stencil_blur_rgb_unit.
`default_nettype none

module csb_checker
  import csb_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     pready,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [RGB_BITS-1:0]      m_axis_tdata,
  input wire logic                     m_axis_tlast,
  input wire logic [0:0]               m_axis_tuser
);

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // The final pixel of a frame always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("end of frame without last of run");

  // The input is only held off while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port not ready");

endmodule

bind cross_stencil_blur_rgb_unit csb_checker u_checker (.*);

`default_nettype wire
